@@ hw/rtl/spte_pkg.sv @@
`default_nettype none

package spte_pkg;

    localparam int DATA_W       = 32;
    localparam int EXP_W        = 5;
    localparam int MAX_EXPONENT = 31;
    localparam int IN_TDATA_W   = 48;
    localparam int ADDR_W       = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_X_POINT = 2'd0;
    localparam logic [1:0] REG_Y_POINT = 2'd1;
    localparam logic [1:0] REG_Z_POINT = 2'd2;

    // Variable selectors used by the sequencer.
    localparam logic [1:0] VAR_X = 2'd0;
    localparam logic [1:0] VAR_Y = 2'd1;
    localparam logic [1:0] VAR_Z = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] z_point;
        logic [DATA_W-1:0] y_point;
        logic [DATA_W-1:0] x_point;
    } spte_points_t;

    typedef struct packed {
        logic busy;
        logic out_load;
    } spte_status_t;

    function automatic logic [EXP_W-1:0] sat_exp(input logic [EXP_W-1:0] e);
        if (32'(e) > MAX_EXPONENT)
        begin
            return EXP_W'(MAX_EXPONENT);
        end
        return e;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sparse_poly_term_evaluator_top.sv @@
// Each term is processed in order: a load step, then five multiply and four
// square steps per variable on the single shared 32x32 multiplier, then an
// add step. A new term is accepted only once the previous one has finished
// its add step; a last term waits in its add step while the previous result
// is still held, and its result appears in the cycle after the add.
// Reset (rst_n, asynchronous, active low) clears the points, sum and output valid.
`default_nettype none

module sparse_poly_term_evaluator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spte_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // coefficient[31:0], power_of_x[36:32], power_of_y[41:37],
    // power_of_z[46:42], zero pad[47]
    input  wire logic [spte_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // poly_value[31:0]
    output logic      [spte_pkg::DATA_W-1:0]   m_tdata
);
    import spte_pkg::*;

    spte_points_t      points;
    spte_status_t      status;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] mul_p;

    spte_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .points  (points)
    );

    spte_mul u_mul (
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    spte_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .points   (points),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p),
        .status   (status)
    );

    // A term occupies the sequencer, so the input closes right after a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input stayed open after accepting a term");

    // A new result only appears after a last term finished its add step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(status.out_load))
        else $error("result raised without a completed last term");

    // While a result is loaded the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.out_load |=> !status.busy)
        else $error("sequencer still busy after emitting a result");

endmodule

`default_nettype wire

@@ hw/rtl/spte_regs.sv @@
`default_nettype none

module spte_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [spte_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output spte_pkg::spte_points_t          points
);
    import spte_pkg::*;

    logic [DATA_W-1:0] x_point_reg;
    logic [DATA_W-1:0] y_point_reg;
    logic [DATA_W-1:0] z_point_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_point_reg <= '0;
            y_point_reg <= '0;
            z_point_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_X_POINT: x_point_reg <= pwdata;
                REG_Y_POINT: y_point_reg <= pwdata;
                REG_Z_POINT: z_point_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_X_POINT: prdata = x_point_reg;
            REG_Y_POINT: prdata = y_point_reg;
            REG_Z_POINT: prdata = z_point_reg;
            default:     prdata = '0;
        endcase
    end

    assign points.x_point = x_point_reg;
    assign points.y_point = y_point_reg;
    assign points.z_point = z_point_reg;

endmodule

`default_nettype wire

@@ hw/rtl/spte_mul.sv @@
`default_nettype none

module spte_mul (
    input  wire logic [spte_pkg::DATA_W-1:0] op_a,
    input  wire logic [spte_pkg::DATA_W-1:0] op_b,
    output logic      [spte_pkg::DATA_W-1:0] product
);
    import spte_pkg::*;

    // Only the low word is kept, so signed and unsigned products agree.
    assign product = DATA_W'(op_a * op_b);

endmodule

`default_nettype wire

@@ hw/rtl/spte_seq.sv @@
`default_nettype none

module spte_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [spte_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [spte_pkg::DATA_W-1:0]   m_tdata,
    input  wire spte_pkg::spte_points_t        points,
    output logic      [spte_pkg::DATA_W-1:0]   mul_a,
    output logic      [spte_pkg::DATA_W-1:0]   mul_b,
    input  wire logic [spte_pkg::DATA_W-1:0]   mul_p,
    output spte_pkg::spte_status_t             status
);
    import spte_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_SPARE = 5'b10000
    } state_t;

    localparam logic [2:0] LAST_BIT = 3'(EXP_W - 1);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [1:0]        var_reg, var_next;
    logic [2:0]        bit_reg, bit_next;
    logic [EXP_W-1:0]  ex_reg, ex_next;
    logic [EXP_W-1:0]  ey_reg, ey_next;
    logic [EXP_W-1:0]  ez_reg, ez_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [EXP_W-1:0]  cur_exp;
    logic [DATA_W-1:0] term_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_ADD) && last_reg && out_free;
    assign term_sum = sum_reg + acc_reg;

    always_comb
    begin
        case (var_reg)
            VAR_X:   cur_exp = ex_reg;
            VAR_Y:   cur_exp = ey_reg;
            VAR_Z:   cur_exp = ez_reg;
            default: cur_exp = '0;
        endcase
    end

    // The shared multiplier squares in the square step and otherwise folds
    // the current power of two into the running term.
    assign mul_a = (state_reg == ST_SQR) ? sq_reg : acc_reg;
    assign mul_b = sq_reg;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        var_next       = var_reg;
        bit_next       = bit_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        ez_next        = ez_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    acc_next   = s_tdata[DATA_W-1:0];
                    ex_next    = sat_exp(s_tdata[DATA_W +: EXP_W]);
                    ey_next    = sat_exp(s_tdata[DATA_W+EXP_W +: EXP_W]);
                    ez_next    = sat_exp(s_tdata[DATA_W+2*EXP_W +: EXP_W]);
                    last_next  = s_tlast;
                    sq_next    = points.x_point;
                    var_next   = VAR_X;
                    bit_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cur_exp[bit_reg])
                begin
                    acc_next = mul_p;
                end
                if (bit_reg != LAST_BIT)
                begin
                    state_next = ST_SQR;
                end
                else
                begin
                    bit_next = '0;
                    case (var_reg)
                        VAR_X:
                        begin
                            var_next = VAR_Y;
                            sq_next  = points.y_point;
                        end
                        VAR_Y:
                        begin
                            var_next = VAR_Z;
                            sq_next  = points.z_point;
                        end
                        default:
                        begin
                            state_next = ST_ADD;
                        end
                    endcase
                end
            end
            ST_SQR:
            begin
                sq_next    = mul_p;
                bit_next   = bit_reg + 3'd1;
                state_next = ST_MUL;
            end
            ST_ADD:
            begin
                if (!last_reg)
                begin
                    sum_next   = term_sum;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = term_sum;
                    sum_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            var_reg       <= VAR_X;
            bit_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            var_reg       <= var_next;
            bit_reg       <= bit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ez_reg       <= ez_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign status.busy     = (state_reg != ST_IDLE);
    assign status.out_load = out_load;

endmodule

`default_nettype wire
